>>> rtl/cfmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfmb_pkg;

	localparam int DIM_W       = 14;
	localparam int RATE_W      = 8;
	localparam int TYPE_W      = 4;
	localparam int POS_W       = 8;
	localparam int MAX_FORMATS = 256;
	localparam int IDX_W       = $clog2(MAX_FORMATS);
	localparam int CNT_W       = $clog2(MAX_FORMATS + 1);
	localparam int DIM_DIFF_W  = DIM_W + 2;
	localparam int RATE_DIFF_W = RATE_W + 2;

	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 4;
	localparam int REG_IDX_W   = 2;

	localparam logic [REG_IDX_W-1:0] REG_WANT_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WANT_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WANT_FPS    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_WANT_TYPE   = 2'd3;

	localparam logic [TYPE_W-1:0] TYPE_I420 = 4'd1;
	localparam logic [TYPE_W-1:0] TYPE_YUY2 = 4'd2;
	localparam logic [TYPE_W-1:0] TYPE_YV12 = 4'd3;

	localparam logic [DIM_W-1:0]  WANT_WIDTH_RST  = 14'd640;
	localparam logic [DIM_W-1:0]  WANT_HEIGHT_RST = 14'd480;
	localparam logic [RATE_W-1:0] WANT_FPS_RST    = 8'd30;
	localparam logic [TYPE_W-1:0] WANT_TYPE_RST   = TYPE_I420;

	typedef struct packed {
		logic [DIM_W-1:0]  want_width;
		logic [DIM_W-1:0]  want_height;
		logic [RATE_W-1:0] want_fps;
		logic [TYPE_W-1:0] want_type;
	} cfmb_cfg_t;

	// Running best of the current list. The kept width, height and rate are
	// the comparison basis; the chosen fields describe the selected format.
	typedef struct packed {
		logic [DIM_W-1:0]  keep_width;
		logic [DIM_W-1:0]  keep_height;
		logic [RATE_W-1:0] keep_rate;
		logic [TYPE_W-1:0] keep_type;
		logic              keep_valid;
		logic [IDX_W-1:0]  keep_index;
		logic [DIM_W-1:0]  chosen_width;
		logic [DIM_W-1:0]  chosen_height;
		logic [RATE_W-1:0] chosen_rate;
	} cfmb_keep_t;

	localparam cfmb_keep_t KEEP_CLEAR = '0;

endpackage

`default_nettype wire

>>> rtl/cfmb_cap_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cfmb_cap_if
	import cfmb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DIM_W-1:0]  cap_width;
	logic [DIM_W-1:0]  cap_height;
	logic [RATE_W-1:0] cap_fps;
	logic [TYPE_W-1:0] cap_type;
	logic              last_cap;

	modport source (
		output valid, cap_width, cap_height, cap_fps, cap_type, last_cap,
		input  ready
	);
	modport sink (
		input  valid, cap_width, cap_height, cap_fps, cap_type, last_cap,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/cfmb_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cfmb_res_if
	import cfmb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              found;
	logic [POS_W-1:0]  best_pos;
	logic [DIM_W-1:0]  best_w;
	logic [DIM_W-1:0]  best_h;
	logic [RATE_W-1:0] best_rate;
	logic [TYPE_W-1:0] best_kind;

	modport source (
		output valid, found, best_pos, best_w, best_h, best_rate, best_kind,
		input  ready
	);
	modport sink (
		input  valid, found, best_pos, best_w, best_h, best_rate, best_kind,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/cfmb_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cfmb_apb_regs
	import cfmb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfmb_cfg_t                  cfg
);

	cfmb_cfg_t              cfg_q;
	logic                   wr_en;
	logic [REG_IDX_W-1:0]   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.want_width  <= WANT_WIDTH_RST;
			cfg_q.want_height <= WANT_HEIGHT_RST;
			cfg_q.want_fps    <= WANT_FPS_RST;
			cfg_q.want_type   <= WANT_TYPE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WANT_WIDTH:  cfg_q.want_width  <= pwdata[DIM_W-1:0];
				REG_WANT_HEIGHT: cfg_q.want_height <= pwdata[DIM_W-1:0];
				REG_WANT_FPS:    cfg_q.want_fps    <= pwdata[RATE_W-1:0];
				REG_WANT_TYPE:   cfg_q.want_type   <= pwdata[TYPE_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_WANT_WIDTH:  prdata = APB_DATA_W'(cfg_q.want_width);
			REG_WANT_HEIGHT: prdata = APB_DATA_W'(cfg_q.want_height);
			REG_WANT_FPS:    prdata = APB_DATA_W'(cfg_q.want_fps);
			REG_WANT_TYPE:   prdata = APB_DATA_W'(cfg_q.want_type);
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/cfmb_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module cfmb_eval
	import cfmb_pkg::*;
(
	input  wire logic              en,
	input  wire cfmb_cfg_t         cfg,
	input  wire cfmb_keep_t        cur,
	input  wire logic [IDX_W-1:0]  pos,
	input  wire logic [DIM_W-1:0]  cap_width,
	input  wire logic [DIM_W-1:0]  cap_height,
	input  wire logic [RATE_W-1:0] cap_fps,
	input  wire logic [TYPE_W-1:0] cap_type,
	output cfmb_keep_t             nxt
);

	logic signed [DIM_DIFF_W-1:0]  dw, dh, bw, bh, mag_bw, mag_bh;
	logic signed [RATE_DIFF_W-1:0] dr, br;
	logic                          ok_h, ok_w, ok_r, pref_type;
	cfmb_keep_t                    take_all, choose_only;

	always_comb begin
		dw = $signed({2'b00, cap_width})       - $signed({2'b00, cfg.want_width});
		dh = $signed({2'b00, cap_height})      - $signed({2'b00, cfg.want_height});
		bw = $signed({2'b00, cur.keep_width})  - $signed({2'b00, cfg.want_width});
		bh = $signed({2'b00, cur.keep_height}) - $signed({2'b00, cfg.want_height});
		dr = $signed({2'b00, cap_fps})         - $signed({2'b00, cfg.want_fps});
		br = $signed({2'b00, cur.keep_rate})   - $signed({2'b00, cfg.want_fps});

		mag_bw = bw[DIM_DIFF_W-1] ? -bw : bw;
		mag_bh = bh[DIM_DIFF_W-1] ? -bh : bh;

		// A candidate fits if it is at or above the request and no farther
		// than the kept one, or if the kept one is short and this is no lower.
		ok_h = (!dh[DIM_DIFF_W-1] && dh <= mag_bh) || (bh[DIM_DIFF_W-1] && dh >= bh);
		ok_w = (!dw[DIM_DIFF_W-1] && dw <= mag_bw) || (bw[DIM_DIFF_W-1] && dw >= bw);
		ok_r = (!dr[RATE_DIFF_W-1] && dr <= br) || (br[RATE_DIFF_W-1] && dr >= br);

		pref_type = (cap_type == cfg.want_type) || (cap_type == TYPE_I420) ||
			(cap_type == TYPE_YUY2) || (cap_type == TYPE_YV12);

		choose_only               = cur;
		choose_only.keep_valid    = 1'b1;
		choose_only.keep_index    = pos;
		choose_only.keep_type     = cap_type;
		choose_only.chosen_width  = cap_width;
		choose_only.chosen_height = cap_height;
		choose_only.chosen_rate   = cap_fps;

		take_all             = choose_only;
		take_all.keep_width  = cap_width;
		take_all.keep_height = cap_height;
		take_all.keep_rate   = cap_fps;

		nxt = cur;
		priority if (!en || !ok_h) begin
			nxt = cur;
		end else if (dh != bh) begin
			nxt = take_all;
		end else if (!ok_w) begin
			nxt = cur;
		end else if (dw != bw) begin
			nxt = take_all;
		end else if (!ok_r) begin
			nxt = cur;
		end else if (dr == br || !br[RATE_DIFF_W-1]) begin
			// Rate tie or already good enough: only the type can improve.
			if (cur.keep_type != cfg.want_type && pref_type) begin
				nxt = choose_only;
			end
		end else begin
			nxt = take_all;
		end
	end

endmodule

`default_nettype wire

>>> rtl/capture_format_best_match_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Capture format best match. Offered formats arrive one word per cycle on
// cap_in while cap_in.ready is high; the word marked last_cap closes the list
// and produces one result word on res_out giving the best format by height,
// then width, then frame rate, then pixel type. The block sustains one word
// per clock unless a result word is left waiting: each word sits in the input
// register while a single compare stage checks it against the kept best;
// the result register loads as the last word leaves the input register. Only
// a result word left waiting on res_out holds back the next last word. Only the
// first MAX_FORMATS words of a list take part. The user must set the target in
// the APB registers while no list is in progress; the block does not enforce it.
module capture_format_best_match_core
	import cfmb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	cfmb_cap_if.sink                   cap_in,
	cfmb_res_if.source                 res_out
);

	cfmb_cfg_t         cfg;
	cfmb_keep_t        keep_q, keep_nxt;
	logic [CNT_W-1:0]  count_q;
	logic              in_room;

	logic              valid_s1;
	logic [DIM_W-1:0]  width_s1, height_s1;
	logic [RATE_W-1:0] fps_s1;
	logic [TYPE_W-1:0] type_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic              advance, in_take;

	cfmb_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_room = count_q < CNT_W'(MAX_FORMATS);

	cfmb_eval u_eval (
		.en         (in_room),
		.cfg        (cfg),
		.cur        (keep_q),
		.pos        (count_q[IDX_W-1:0]),
		.cap_width  (width_s1),
		.cap_height (height_s1),
		.cap_fps    (fps_s1),
		.cap_type   (type_s1),
		.nxt        (keep_nxt)
	);

	// A last word can only leave the input register when the result slot is free.
	assign advance      = valid_s1 && (!last_s1 || !out_valid_q || res_out.ready);
	assign cap_in.ready = !valid_s1 || advance;
	assign in_take      = cap_in.valid && cap_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			width_s1  <= cap_in.cap_width;
			height_s1 <= cap_in.cap_height;
			fps_s1    <= cap_in.cap_fps;
			type_s1   <= cap_in.cap_type;
			last_s1   <= cap_in.last_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q  <= KEEP_CLEAR;
			count_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				keep_q  <= KEEP_CLEAR;
				count_q <= '0;
			end else begin
				keep_q <= keep_nxt;
				if (in_room) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The cleared search state holds zeros, so a list with no choice
	// reports all-zero fields without extra muxing.
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_out.found     <= keep_nxt.keep_valid;
			res_out.best_pos  <= POS_W'(keep_nxt.keep_index);
			res_out.best_w    <= keep_nxt.chosen_width;
			res_out.best_h    <= keep_nxt.chosen_height;
			res_out.best_rate <= keep_nxt.chosen_rate;
			res_out.best_kind <= keep_nxt.keep_type;
		end
	end

	assign res_out.valid = out_valid_q;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
	import cfmb_pkg::*;

	localparam int DIM_MAX  = (1 << DIM_W) - 1;
	localparam int RATE_MAX = (1 << RATE_W) - 1;
	localparam int TYPE_MAX = (1 << TYPE_W) - 1;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [RATE_W-1:0] fps;
		logic [TYPE_W-1:0] kind;
		logic              last;
	} offer_t;

	typedef struct {
		logic              found;
		logic [POS_W-1:0]  pos;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [RATE_W-1:0] rate;
		logic [TYPE_W-1:0] kind;
	} pick_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cfmb_cap_if cap_if ();
	cfmb_res_if res_if ();

	capture_format_best_match_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap_in  (cap_if),
		.res_out (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requested format as currently programmed.
	int                tgt_w    = WANT_WIDTH_RST;
	int                tgt_h    = WANT_HEIGHT_RST;
	int                tgt_fps  = WANT_FPS_RST;
	logic [TYPE_W-1:0] tgt_type = WANT_TYPE_RST;

	// Running best of the list in progress. run_w/h/rate are what later
	// offers are compared against; sel_* describe the format picked.
	int                run_w, run_h, run_rate;
	logic [TYPE_W-1:0] run_kind;
	bit                run_valid;
	int                run_pos;
	int                list_len;
	int                sel_w, sel_h, sel_rate;

	offer_t offers_q[$];
	pick_t  picks_due[$];
	int     offers_sent  = 0;
	int     offers_taken = 0;
	int     fail_count   = 0;

	offer_t   in_flight;
	offer_t   next_offer;
	bit       tx_hold;
	int       burst_left = 0;
	int       gap_left   = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_age  = 0;
	logic     rx_next;

	task automatic clear_run();
		run_w     = 0;
		run_h     = 0;
		run_rate  = 0;
		run_kind  = '0;
		run_valid = 1'b0;
		run_pos   = 0;
		list_len  = 0;
		sel_w     = 0;
		sel_h     = 0;
		sel_rate  = 0;
	endtask

	function automatic int absval(int v);
		return (v < 0) ? -v : v;
	endfunction

	// An offer is no worse in one dimension when it is at or above the
	// target and no further off than the kept one, or when the kept one is
	// below target and the offer is no lower.
	function automatic bit no_worse(int d, int b);
		return (d >= 0 && d <= absval(b)) || (b < 0 && d >= b);
	endfunction

	task automatic adopt(int pos, offer_t o, bit rebase);
		if (rebase) begin
			run_w    = o.w;
			run_h    = o.h;
			run_rate = o.fps;
		end
		run_valid = 1'b1;
		run_pos   = pos;
		run_kind  = o.kind;
		sel_w     = o.w;
		sel_h     = o.h;
		sel_rate  = o.fps;
	endtask

	task automatic rank_format(offer_t o);
		int    dw, dh, dr, bw, bh, br;
		pick_t p;
		if (list_len < MAX_FORMATS) begin
			dw = int'(o.w) - tgt_w;
			dh = int'(o.h) - tgt_h;
			dr = int'(o.fps) - tgt_fps;
			bw = run_w - tgt_w;
			bh = run_h - tgt_h;
			br = run_rate - tgt_fps;
			if (no_worse(dh, bh)) begin
				if (dh != bh) begin
					adopt(list_len, o, 1'b1);
				end else if (no_worse(dw, bw)) begin
					if (dw != bw) begin
						adopt(list_len, o, 1'b1);
					end else if ((dr >= 0 && dr <= br) || (br < 0 && dr >= br)) begin
						if (dr == br || br >= 0) begin
							// Rate ties or is already good enough: only the type decides.
							if (run_kind != tgt_type && (o.kind == tgt_type ||
									o.kind == TYPE_I420 || o.kind == TYPE_YUY2 ||
									o.kind == TYPE_YV12))
								adopt(list_len, o, 1'b0);
						end else begin
							adopt(list_len, o, 1'b1);
						end
					end
				end
			end
			list_len++;
		end
		if (o.last) begin
			p.found = run_valid;
			p.pos   = run_valid ? run_pos[POS_W-1:0] : '0;
			p.w     = run_valid ? sel_w[DIM_W-1:0] : '0;
			p.h     = run_valid ? sel_h[DIM_W-1:0] : '0;
			p.rate  = run_valid ? sel_rate[RATE_W-1:0] : '0;
			p.kind  = run_valid ? run_kind : '0;
			picks_due.insert(picks_due.size(), p);
			clear_run();
		end
	endtask

	task automatic check_pick();
		pick_t e;
		if (picks_due.size() == 0) begin
			$error("result word with no expected result pending");
			fail_count++;
		end else begin
			e = picks_due.pop_front();
			if (res_if.found !== e.found) begin
				$error("found: expected %0d, actual %0d", e.found, res_if.found);
				fail_count++;
			end
			if (res_if.best_pos !== e.pos) begin
				$error("best_pos: expected %0d, actual %0d", e.pos, res_if.best_pos);
				fail_count++;
			end
			if (res_if.best_w !== e.w) begin
				$error("best_w: expected %0d, actual %0d", e.w, res_if.best_w);
				fail_count++;
			end
			if (res_if.best_h !== e.h) begin
				$error("best_h: expected %0d, actual %0d", e.h, res_if.best_h);
				fail_count++;
			end
			if (res_if.best_rate !== e.rate) begin
				$error("best_rate: expected %0d, actual %0d", e.rate, res_if.best_rate);
				fail_count++;
			end
			if (res_if.best_kind !== e.kind) begin
				$error("best_kind: expected %0d, actual %0d", e.kind, res_if.best_kind);
				fail_count++;
			end
		end
	endtask

	// Sender: bursts of words from the queue with random gaps in between.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_if.valid <= 1'b0;
		end else begin
			tx_hold = 1'b0;
			if (cap_if.valid && cap_if.ready) begin
				rank_format(in_flight);
				offers_taken++;
			end else if (cap_if.valid) begin
				tx_hold = 1'b1;
			end
			if (!tx_hold) begin
				if (gap_left > 0 || offers_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					cap_if.valid <= 1'b0;
				end else begin
					next_offer = offers_q.pop_front();
					in_flight  = next_offer;
					cap_if.valid      <= 1'b1;
					cap_if.cap_width  <= next_offer.w;
					cap_if.cap_height <= next_offer.h;
					cap_if.cap_fps    <= next_offer.fps;
					cap_if.cap_type   <= next_offer.kind;
					cap_if.last_cap   <= next_offer.last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
							: $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Receiver: checks each result word and stalls on a changing pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready)
				check_pick();
			if (rx_age == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_age  = $urandom_range(16, 96);
			end else begin
				rx_age--;
			end
			case (rx_mode)
				RX_OPEN:   rx_next = 1'b1;
				RX_COIN:   rx_next = 1'($urandom_range(0, 1));
				RX_SPARSE: rx_next = ($urandom_range(0, 7) == 0);
				default:   rx_next = ~res_if.ready;
			endcase
			res_if.ready <= rx_next;
		end
	end

	task automatic offer(int w, int h, int fps, int kind, bit last);
		offer_t o;
		o.w    = DIM_W'(w);
		o.h    = DIM_W'(h);
		o.fps  = RATE_W'(fps);
		o.kind = TYPE_W'(kind);
		o.last = last;
		offers_q.insert(offers_q.size(), o);
		offers_sent++;
	endtask

	// Wait until every word is taken and every result checked, then let the
	// pipeline drain before anything is reprogrammed.
	task automatic settle();
		while (offers_taken != offers_sent || picks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_WANT_WIDTH:  tgt_w    = val[DIM_W-1:0];
			REG_WANT_HEIGHT: tgt_h    = val[DIM_W-1:0];
			REG_WANT_FPS:    tgt_fps  = val[RATE_W-1:0];
			REG_WANT_TYPE:   tgt_type = val[TYPE_W-1:0];
			default: ;
		endcase
	endtask

	// Upper data bits are random so that the field masking is exercised.
	task automatic set_target(int w, int h, int fps, int kind);
		reg_write(REG_WANT_WIDTH, ($urandom() & ~DIM_MAX) | w);
		reg_write(REG_WANT_HEIGHT, ($urandom() & ~DIM_MAX) | h);
		reg_write(REG_WANT_FPS, ($urandom() & ~RATE_MAX) | fps);
		reg_write(REG_WANT_TYPE, ($urandom() & ~TYPE_MAX) | kind);
	endtask

	function automatic int pick_near(int tgt, int maxv);
		int v;
		case ($urandom_range(0, 7))
			0, 1:    v = tgt;
			2:       v = tgt + int'($urandom_range(0, 8)) - 4;
			3:       v = 0;
			4:       v = maxv;
			default: v = $urandom_range(0, maxv);
		endcase
		if (v < 0)
			v = 0;
		if (v > maxv)
			v = maxv;
		return v;
	endfunction

	function automatic int pick_kind();
		case ($urandom_range(0, 3))
			0:       return tgt_type;
			1:       return $urandom_range(TYPE_I420, TYPE_YV12);
			default: return $urandom_range(0, TYPE_MAX);
		endcase
	endfunction

	// Offers cluster around the target and often repeat the previous size
	// and rate, so the width, rate and type tie branches are reached.
	task automatic random_list(int len);
		int k, w, h, fps;
		w   = 0;
		h   = 0;
		fps = 0;
		for (k = 0; k < len; k++) begin
			if (k == 0 || $urandom_range(0, 3) != 0) begin
				w   = pick_near(tgt_w, DIM_MAX);
				h   = pick_near(tgt_h, DIM_MAX);
				fps = pick_near(tgt_fps, RATE_MAX);
			end else if ($urandom_range(0, 1) == 0) begin
				fps = pick_near(tgt_fps, RATE_MAX);
			end
			offer(w, h, fps, pick_kind(), k == len - 1);
		end
	endtask

	initial begin
		int w, h, fps, kind;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cap_if.valid      = 1'b0;
		cap_if.cap_width  = '0;
		cap_if.cap_height = '0;
		cap_if.cap_fps    = '0;
		cap_if.cap_type   = '0;
		cap_if.last_cap   = 1'b0;
		res_if.ready      = 1'b0;
		clear_run();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset target 640x480 at 30, I420. Height first, then width, then rate; with the kept
		// rate at or above target, a no worse rate moves only the choice, so the final pick is
		// position 4 while later offers compare against the 60 fps one.
		offer(320, 240, 30, TYPE_YUY2, 1'b0);
		offer(640, 480, 60, TYPE_YUY2, 1'b0);
		offer(640, 480, 30, TYPE_YUY2, 1'b0);
		offer(640, 480, 25, TYPE_I420, 1'b0);
		offer(640, 480, 30, TYPE_I420, 1'b0);
		offer(640, 480, 30, TYPE_YV12, 1'b0);
		offer(1280, 720, 30, TYPE_I420, 1'b0);
		offer(DIM_MAX, DIM_MAX, RATE_MAX, TYPE_MAX, 1'b0);
		offer(0, 0, 0, 0, 1'b1);
		offer(DIM_MAX, DIM_MAX, RATE_MAX, TYPE_MAX, 1'b1);
		// An all-zero offer ties the empty best but has no preferred type.
		offer(0, 0, 0, 0, 1'b1);
		settle();

		// Unknown requested type: a tie never moves the choice, nothing found.
		set_target(0, 0, 0, 0);
		offer(5, 0, 0, TYPE_I420, 1'b0);
		offer(0, 0, 0, TYPE_YUY2, 1'b1);
		settle();

		set_target(DIM_MAX, DIM_MAX, RATE_MAX, TYPE_MAX);
		offer(DIM_MAX, DIM_MAX, RATE_MAX, 0, 1'b0);
		offer(DIM_MAX, DIM_MAX, RATE_MAX, TYPE_MAX, 1'b0);
		offer(DIM_MAX, DIM_MAX, RATE_MAX, TYPE_YUY2, 1'b1);
		settle();

		while (offers_sent < 550) begin
			case ($urandom_range(0, 4))
				0: begin
					w    = 640 + int'($urandom_range(0, 64)) - 32;
					h    = 480 + int'($urandom_range(0, 64)) - 32;
					fps  = $urandom_range(15, 60);
					kind = $urandom_range(TYPE_I420, TYPE_YV12);
				end
				1: begin
					w    = $urandom_range(0, 1) ? DIM_MAX : 0;
					h    = $urandom_range(0, 1) ? DIM_MAX : 0;
					fps  = $urandom_range(0, 1) ? RATE_MAX : 0;
					kind = $urandom_range(0, 1) ? TYPE_MAX : 0;
				end
				default: begin
					w    = $urandom_range(0, DIM_MAX);
					h    = $urandom_range(0, DIM_MAX);
					fps  = $urandom_range(0, RATE_MAX);
					kind = $urandom_range(0, TYPE_MAX);
				end
			endcase
			set_target(w, h, fps, kind);
			repeat ($urandom_range(4, 12))
				random_list(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12));
			settle();
		end

		// Lists at and past the format limit; the overflow words take no part
		// beyond closing the list.
		set_target(640, 480, 30, TYPE_I420);
		random_list(MAX_FORMATS);
		random_list($urandom_range(MAX_FORMATS + 1, MAX_FORMATS + 40));
		random_list(3);
		settle();

		if (fail_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/cfmb_pkg.sv
rtl/cfmb_cap_if.sv
rtl/cfmb_res_if.sv
rtl/cfmb_apb_regs.sv
rtl/cfmb_eval.sv
rtl/capture_format_best_match_core.sv
test/tb.sv
